FILE: hdl/idll_pkg.sv
`default_nettype none

package idll_pkg;

    localparam int ID_W  = 10;
    localparam int NODES = 1 << ID_W;

    typedef logic [ID_W-1:0] id_t;

    localparam id_t ID_NONE = '0;
    localparam id_t ID_MAX  = id_t'(NODES - 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TARGET_ABSENT = 3'd1,
        ST_FULL          = 3'd2,
        ST_ANCHOR_ABSENT = 3'd3,
        ST_EMPTY         = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_EVAL,
        S_INS_LINK,
        S_RM_EVAL,
        S_RD_EVAL,
        S_RD_LAST,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  anchor;
        logic        side;
        logic [9:0]  target;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  new_id;
        logic [9:0]  read_id;
        logic        last;
    } res_t;

    // One read address for all three tables, one write port per table.
    typedef struct packed {
        id_t   rd_addr;
        logic  next_we;
        id_t   next_addr;
        id_t   next_data;
        logic  prev_we;
        id_t   prev_addr;
        id_t   prev_data;
        logic  pres_we;
        id_t   pres_addr;
        logic  pres_data;
    } store_req_t;

    typedef struct packed {
        id_t   next;
        id_t   prev;
        logic  present;
    } store_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/idll_store.sv
`default_nettype none

module idll_store (
    input  wire                   clk,
    input  wire                   rst_n,
    input  idll_pkg::store_req_t  req,
    input  idll_pkg::id_t         last_id,
    output idll_pkg::store_rsp_t  rsp
);

    idll_pkg::id_t next_mem [idll_pkg::NODES];
    idll_pkg::id_t prev_mem [idll_pkg::NODES];
    logic          pres_mem [idll_pkg::NODES];

    idll_pkg::id_t next_q;
    idll_pkg::id_t prev_q;
    logic          pres_q;

    idll_pkg::id_t raddr_reg;
    logic          rd_ok_reg;
    logic          next0_wr_reg;
    logic          next1_wr_reg;
    logic          prev0_wr_reg;
    logic          prev1_wr_reg;
    logic          pres1_reg;

    always_ff @(posedge clk)
    begin
        if (req.next_we)
        begin
            next_mem[req.next_addr] <= req.next_data;
        end
        if (req.prev_we)
        begin
            prev_mem[req.prev_addr] <= req.prev_data;
        end
        if (req.pres_we)
        begin
            pres_mem[req.pres_addr] <= req.pres_data;
        end
        next_q <= next_mem[req.rd_addr];
        prev_q <= prev_mem[req.rd_addr];
        pres_q <= pres_mem[req.rd_addr];
    end

    // Entries 0 and 1 read their reset links until first written. A present
    // entry above the last issued id was never written and reads as clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raddr_reg    <= idll_pkg::ID_NONE;
            rd_ok_reg    <= 1'b0;
            next0_wr_reg <= 1'b0;
            next1_wr_reg <= 1'b0;
            prev0_wr_reg <= 1'b0;
            prev1_wr_reg <= 1'b0;
            pres1_reg    <= 1'b1;
        end
        else
        begin
            raddr_reg <= req.rd_addr;
            rd_ok_reg <= (req.rd_addr != idll_pkg::ID_NONE) && (req.rd_addr <= last_id);
            if (req.next_we && req.next_addr == idll_pkg::id_t'(0))
            begin
                next0_wr_reg <= 1'b1;
            end
            if (req.next_we && req.next_addr == idll_pkg::id_t'(1))
            begin
                next1_wr_reg <= 1'b1;
            end
            if (req.prev_we && req.prev_addr == idll_pkg::id_t'(0))
            begin
                prev0_wr_reg <= 1'b1;
            end
            if (req.prev_we && req.prev_addr == idll_pkg::id_t'(1))
            begin
                prev1_wr_reg <= 1'b1;
            end
            if (req.pres_we && req.pres_addr == idll_pkg::id_t'(1))
            begin
                pres1_reg <= req.pres_data;
            end
        end
    end

    always_comb
    begin
        rsp.next    = next_q;
        rsp.prev    = prev_q;
        rsp.present = rd_ok_reg & pres_q;
        if (raddr_reg == idll_pkg::id_t'(0))
        begin
            if (!next0_wr_reg)
            begin
                rsp.next = idll_pkg::id_t'(1);
            end
            if (!prev0_wr_reg)
            begin
                rsp.prev = idll_pkg::id_t'(1);
            end
        end
        if (raddr_reg == idll_pkg::id_t'(1))
        begin
            if (!next1_wr_reg)
            begin
                rsp.next = idll_pkg::ID_NONE;
            end
            if (!prev1_wr_reg)
            begin
                rsp.prev = idll_pkg::ID_NONE;
            end
            rsp.present = pres1_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/indexed_doubly_linked_list_core.sv
`default_nettype none

// Ordered list of node ids kept as a doubly linked list in two id-indexed
// link tables, with node 0 as the circular sentinel; after reset the list
// holds node 1 only. One command is worked at a time and gives one result
// beat: an insert runs evaluate, link, emit (a refused one skips the link);
// a remove evaluate, emit; a read evaluate, next-node read, emit, evaluating
// twice when a stale cursor restarts the walk at the head (no next-node read
// on an empty list); an unused op just emits. Each link table has one write
// port (an insert rewrites two entries of each) and each evaluate waits for
// the registered table read. A finished result sits in an output register,
// and the block takes the next command only once that register can load.
module indexed_doubly_linked_list_core (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_stall,
    input  idll_pkg::cmd_t   cmd,
    output logic             res_valid,
    input  wire              res_stall,
    output idll_pkg::res_t   res
);

    idll_pkg::state_t     state_reg, state_next;
    idll_pkg::cmd_t       cmd_reg, cmd_next;
    idll_pkg::res_t       pend_reg, pend_next;
    idll_pkg::res_t       res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;
    idll_pkg::id_t        last_id_reg, last_id_next;
    idll_pkg::id_t        cursor_reg, cursor_next;
    idll_pkg::id_t        left_reg, left_next;
    idll_pkg::id_t        right_reg, right_next;
    idll_pkg::id_t        nx_reg, nx_next;

    idll_pkg::store_req_t sreq;
    idll_pkg::store_rsp_t srsp;

    idll_pkg::id_t        new_id;
    logic                 cmd_take;

    idll_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .last_id (last_id_reg),
        .rsp     (srsp)
    );

    assign cmd_stall = (state_reg != idll_pkg::S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign new_id    = last_id_reg + idll_pkg::id_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idll_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
            last_id_reg   <= idll_pkg::id_t'(1);
            cursor_reg    <= idll_pkg::ID_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            last_id_reg   <= last_id_next;
            cursor_reg    <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        nx_reg    <= nx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        last_id_next   = last_id_reg;
        cursor_next    = cursor_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        nx_next        = nx_reg;

        sreq           = '0;
        sreq.rd_addr   = cursor_reg;

        unique case (state_reg)
            idll_pkg::S_IDLE:
            begin
                pend_next = '{status: idll_pkg::ST_OK, new_id: '0, read_id: '0, last: 1'b0};
                unique case (cmd.op)
                    idll_pkg::OP_INSERT: sreq.rd_addr = cmd.anchor;
                    idll_pkg::OP_REMOVE: sreq.rd_addr = cmd.target;
                    idll_pkg::OP_READ:   sreq.rd_addr = cursor_reg;
                    idll_pkg::OP_NOP:    sreq.rd_addr = cursor_reg;
                    default:             sreq.rd_addr = cursor_reg;
                endcase
                if (cmd_take)
                begin
                    cmd_next = cmd;
                    unique case (cmd.op)
                        idll_pkg::OP_INSERT: state_next = idll_pkg::S_INS_EVAL;
                        idll_pkg::OP_REMOVE: state_next = idll_pkg::S_RM_EVAL;
                        idll_pkg::OP_READ:   state_next = idll_pkg::S_RD_EVAL;
                        idll_pkg::OP_NOP:    state_next = idll_pkg::S_EMIT;
                        default:             state_next = idll_pkg::S_EMIT;
                    endcase
                end
            end

            idll_pkg::S_INS_EVAL:
            begin
                state_next = idll_pkg::S_EMIT;
                if (last_id_reg == idll_pkg::ID_MAX)
                begin
                    pend_next.status = idll_pkg::ST_FULL;
                end
                else if (cmd_reg.anchor == idll_pkg::ID_NONE || !srsp.present)
                begin
                    pend_next.status = idll_pkg::ST_ANCHOR_ABSENT;
                end
                else
                begin
                    if (cmd_reg.side)
                    begin
                        left_next  = cmd_reg.anchor;
                        right_next = srsp.next;
                    end
                    else
                    begin
                        left_next  = srsp.prev;
                        right_next = cmd_reg.anchor;
                    end
                    sreq.next_we   = 1'b1;
                    sreq.next_addr = left_next;
                    sreq.next_data = new_id;
                    sreq.prev_we   = 1'b1;
                    sreq.prev_addr = right_next;
                    sreq.prev_data = new_id;
                    sreq.pres_we   = 1'b1;
                    sreq.pres_addr = new_id;
                    sreq.pres_data = 1'b1;
                    last_id_next   = new_id;
                    state_next     = idll_pkg::S_INS_LINK;
                end
            end

            idll_pkg::S_INS_LINK:
            begin
                // The new id is already the last issued one here.
                sreq.next_we     = 1'b1;
                sreq.next_addr   = last_id_reg;
                sreq.next_data   = right_reg;
                sreq.prev_we     = 1'b1;
                sreq.prev_addr   = last_id_reg;
                sreq.prev_data   = left_reg;
                pend_next.new_id = last_id_reg;
                state_next       = idll_pkg::S_EMIT;
            end

            idll_pkg::S_RM_EVAL:
            begin
                state_next = idll_pkg::S_EMIT;
                if (cmd_reg.target == idll_pkg::ID_NONE || !srsp.present)
                begin
                    pend_next.status = idll_pkg::ST_TARGET_ABSENT;
                end
                else
                begin
                    sreq.next_we   = 1'b1;
                    sreq.next_addr = srsp.prev;
                    sreq.next_data = srsp.next;
                    sreq.prev_we   = 1'b1;
                    sreq.prev_addr = srsp.next;
                    sreq.prev_data = srsp.prev;
                    sreq.pres_we   = 1'b1;
                    sreq.pres_addr = cmd_reg.target;
                    sreq.pres_data = 1'b0;
                end
            end

            idll_pkg::S_RD_EVAL:
            begin
                // A removed cursor node, or a cursor at the tail, restarts the
                // walk from the sentinel.
                priority if ((cursor_reg != idll_pkg::ID_NONE) &&
                             (!srsp.present || srsp.next == idll_pkg::ID_NONE))
                begin
                    cursor_next  = idll_pkg::ID_NONE;
                    sreq.rd_addr = idll_pkg::ID_NONE;
                end
                else if (srsp.next == idll_pkg::ID_NONE)
                begin
                    cursor_next      = idll_pkg::ID_NONE;
                    pend_next.status = idll_pkg::ST_EMPTY;
                    state_next       = idll_pkg::S_EMIT;
                end
                else
                begin
                    nx_next      = srsp.next;
                    sreq.rd_addr = srsp.next;
                    state_next   = idll_pkg::S_RD_LAST;
                end
            end

            idll_pkg::S_RD_LAST:
            begin
                pend_next.read_id = nx_reg;
                pend_next.last    = (srsp.next == idll_pkg::ID_NONE);
                cursor_next       = (srsp.next == idll_pkg::ID_NONE) ? idll_pkg::ID_NONE
                                                                      : nx_reg;
                state_next        = idll_pkg::S_EMIT;
            end

            idll_pkg::S_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = idll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = idll_pkg::S_IDLE;
            end
        endcase
    end

    a_last_id_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        last_id_reg >= $past(last_id_reg))
        else $error("last issued id went backward");

    a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == idll_pkg::S_EMIT))
        else $error("result beat raised outside the emit step");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != idll_pkg::ST_OK |->
            res_reg.new_id == '0 && res_reg.read_id == '0 && !res_reg.last)
        else $error("failed command carries nonzero fields");

    a_cursor_issued: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= last_id_reg)
        else $error("read cursor beyond the last issued id");

endmodule

`default_nettype wire

FILE: dv/idll_list_checker.sv
`timescale 1ns / 1ps

module idll_list_checker (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    input  wire              cmd_stall,
    input  idll_pkg::cmd_t   cmd,
    input  wire              res_valid,
    input  wire              res_stall,
    input  idll_pkg::res_t   res,
    output int               fail_count,
    output int               awaited
);

    import idll_pkg::*;

    // Shadow copy of the link tables; node 0 is the sentinel.
    id_t    fwd_link [NODES];
    id_t    back_link [NODES];
    bit     on_list [NODES];
    id_t    newest_id;
    id_t    walk_pos;

    res_t   awaited_res [$];
    res_t   want;
    int     bad = 0;
    int     i;

    function automatic bit listed(id_t n);
        return n != ID_NONE && on_list[n];
    endfunction

    // Applies one command to the shadow list and returns the result it must produce.
    function automatic res_t apply_list_cmd(cmd_t c);
        res_t r;
        id_t  n;
        id_t  lft;
        id_t  rgt;
        id_t  cur;
        id_t  nx;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            OP_INSERT:
            begin
                if (newest_id == ID_MAX)
                    r.status = ST_FULL;
                else if (!listed(c.anchor))
                    r.status = ST_ANCHOR_ABSENT;
                else
                begin
                    n = newest_id + 1'b1;
                    if (!c.side)
                    begin
                        lft = back_link[c.anchor];
                        rgt = c.anchor;
                    end
                    else
                    begin
                        lft = c.anchor;
                        rgt = fwd_link[c.anchor];
                    end
                    fwd_link[lft] = n;
                    back_link[rgt] = n;
                    back_link[n] = lft;
                    fwd_link[n] = rgt;
                    on_list[n] = 1'b1;
                    newest_id = n;
                    r.new_id = n;
                end
            end
            OP_REMOVE:
            begin
                if (!listed(c.target))
                    r.status = ST_TARGET_ABSENT;
                else
                begin
                    lft = back_link[c.target];
                    rgt = fwd_link[c.target];
                    fwd_link[lft] = rgt;
                    back_link[rgt] = lft;
                    on_list[c.target] = 1'b0;
                end
            end
            OP_READ:
            begin
                // A cursor on a removed node, or one that has become the tail,
                // sends the walk back to the head.
                cur = walk_pos;
                if (cur != ID_NONE && !listed(cur))
                    cur = ID_NONE;
                nx = fwd_link[cur];
                if (nx == ID_NONE)
                    nx = fwd_link[ID_NONE];
                if (nx == ID_NONE)
                begin
                    walk_pos = ID_NONE;
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.read_id = nx;
                    r.last = (fwd_link[nx] == ID_NONE);
                    walk_pos = r.last ? ID_NONE : nx;
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic int field_bad(string name, int exp_val, int act_val);
        if (exp_val == act_val)
            return 0;
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < NODES; i++)
            begin
                fwd_link[i] = ID_NONE;
                back_link[i] = ID_NONE;
                on_list[i] = 1'b0;
            end
            fwd_link[0] = id_t'(1);
            back_link[0] = id_t'(1);
            on_list[1] = 1'b1;
            newest_id = id_t'(1);
            walk_pos = ID_NONE;
            awaited_res.delete();
            awaited <= 0;
            fail_count <= bad;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                awaited_res.push_back(apply_list_cmd(cmd));
            if (res_valid && !res_stall)
            begin
                if (awaited_res.size() == 0)
                begin
                    $error("result beat with no command outstanding: %p", res);
                    bad++;
                end
                else
                begin
                    want = awaited_res.pop_front();
                    bad += field_bad("status", want.status, res.status);
                    bad += field_bad("new_id", want.new_id, res.new_id);
                    bad += field_bad("read_id", want.read_id, res.read_id);
                    bad += field_bad("last", want.last, res.last);
                end
            end
            awaited <= awaited_res.size();
            fail_count <= bad;
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import idll_pkg::*;

    logic   clk;
    logic   rst_n;
    logic   cmd_valid;
    logic   cmd_stall;
    cmd_t   cmd;
    logic   res_valid;
    logic   res_stall = 1'b0;
    res_t   res;
    int     fail_count;
    int     awaited;

    // Stimulus-side view of which ids are on the list, used to aim commands.
    bit     in_use [NODES];
    id_t    members [$];
    int     issued = 1;
    int     items_sent = 0;
    int     phase = 0;
    int     send_pct = 0;
    int     recv_pct = 0;
    bit     hold_go = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_cnt = 0;
    int     i;

    indexed_doubly_linked_list_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    idll_list_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            res_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_go && !hold_done)
        begin
            res_stall <= 1'b1;
            hold_cnt <= 400;
            hold_done <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic cmd_t mk(op_t op, int a, int s, int t);
        cmd_t c;
        c.op = op;
        c.anchor = id_t'(a);
        c.side = s[0];
        c.target = id_t'(t);
        return c;
    endfunction

    function automatic id_t pick_member();
        if (members.size() == 0)
            return id_t'($urandom_range(ID_MAX));
        return members[$urandom_range(members.size() - 1)];
    endfunction

    // Mostly well-aimed commands with random content; keep stops the list from emptying.
    function automatic cmd_t make_cmd(int ins_w, int rm_w, bit keep);
        cmd_t c;
        int   r;
        r = $urandom_range(99);
        c.anchor = ($urandom_range(99) < 85) ? pick_member() : id_t'($urandom_range(ID_MAX));
        c.side = 1'($urandom_range(1));
        c.target = ($urandom_range(99) < 80) ? pick_member() : id_t'($urandom_range(ID_MAX));
        if (r < ins_w)
            c.op = OP_INSERT;
        else if (r < ins_w + rm_w)
            c.op = (keep && members.size() < 2) ? OP_INSERT : OP_REMOVE;
        else if (r < 97)
            c.op = OP_READ;
        else
            c.op = OP_NOP;
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < send_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (c.op == OP_INSERT && issued < ID_MAX && c.anchor != ID_NONE && in_use[c.anchor])
        begin
            issued++;
            in_use[issued] = 1'b1;
            members.push_back(id_t'(issued));
        end
        if (c.op == OP_REMOVE && c.target != ID_NONE && in_use[c.target])
        begin
            in_use[c.target] = 1'b0;
            for (int k = 0; k < members.size(); k++)
                if (members[k] == c.target)
                begin
                    members.delete(k);
                    break;
                end
        end
        items_sent++;
        if (items_sent % 100 == 0)
        begin
            phase = (phase + 1) % 4;
            case (phase)
                0: begin send_pct = 0;  recv_pct <= 0;  end
                1: begin send_pct = 80; recv_pct <= 0;  end
                2: begin send_pct = 0;  recv_pct <= 80; end
                default: begin send_pct = 6; recv_pct <= 6; end
            endcase
            if (phase == 0 && items_sent >= 400)
                hold_go <= 1'b1;
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        for (i = 0; i < NODES; i++)
            in_use[i] = 1'b0;
        in_use[1] = 1'b1;
        members.push_back(id_t'(1));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: insert both sides, absent anchors and targets, read wrap,
        // stale cursor after removal and after the cursor becomes the tail.
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_INSERT, 1, 1, 0));
        send_cmd(mk(OP_INSERT, 1, 0, 0));
        send_cmd(mk(OP_INSERT, 0, 1, 0));
        send_cmd(mk(OP_INSERT, ID_MAX, 1, 0));
        send_cmd(mk(OP_INSERT, 682, 0, 341));
        send_cmd(mk(OP_REMOVE, 0, 0, 0));
        send_cmd(mk(OP_REMOVE, 0, 0, ID_MAX));
        send_cmd(mk(OP_REMOVE, 0, 0, 7));
        send_cmd(mk(OP_NOP, ID_MAX, 1, ID_MAX));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_INSERT, 2, 1, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_REMOVE, 0, 0, 2));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_REMOVE, 0, 0, 4));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_REMOVE, 0, 0, 2));
        send_cmd(mk(OP_INSERT, 2, 0, 0));
        send_cmd(mk(OP_INSERT, 3, 0, 0));

        for (i = 0; i < 600; i++)
            send_cmd(make_cmd(35, 30, 1'b1));

        // Tear the list down to empty with reads walking it as it shrinks.
        while (members.size() != 0)
            send_cmd(make_cmd(0, 70, 1'b0));
        send_cmd(mk(OP_READ, 0, 0, 0));
        send_cmd(mk(OP_READ, ID_MAX, 1, ID_MAX));
        send_cmd(mk(OP_REMOVE, 0, 0, 1));
        send_cmd(mk(OP_INSERT, 1, 1, 0));
        send_cmd(mk(OP_NOP, 0, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0));

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
